// ----- rtl/core/sbsh_pkg.sv -----
// Shared constants, state codes and round functions for the SHA-256 byte stream hasher.
`default_nettype none
package sbsh_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORDS    = 8;
	localparam int unsigned WIN_WORDS = 16;
	localparam int unsigned ROUNDS   = 64;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 40;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd7;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_ADD   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	typedef logic [WORD_W-1:0] word_t;

	function automatic word_t init_word(input logic [2:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		word_t r;
		case (t)
			6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t big_s0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_s1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_s0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_s1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sha256_byte_stream_hasher.sv -----
// Top level: SHA-256 over a byte stream with one shared round unit under a small sequencer.
// Message bytes: one transfer per cycle while s_axis_tready is high; every 64th byte starts the
// rounds and then the chaining add, during which s_axis_tready is low.
// End of message: padding bytes fill out one or two blocks, each followed by a compression,
// then the eight digest words leave one per cycle while m_axis_tready is high.
// Reset loads the initial hash values and clears the counters; ready right after reset.
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic             m_axis_tlast    // last_word
);

	sbsh_pkg::state_t  state_q;
	sbsh_pkg::word_t   chain_q [sbsh_pkg::WORDS];
	sbsh_pkg::word_t   v_q     [sbsh_pkg::WORDS];
	sbsh_pkg::word_t   w_q     [sbsh_pkg::WIN_WORDS];
	logic [5:0]        fill_q;
	logic [5:0]        round_q;
	logic [63:0]       total_q;
	logic [2:0]        idx_q;
	logic              pad_q;
	logic              sent80_q;
	logic              len_q;
	logic              fin_q;

	logic              in_xfer;
	logic              out_xfer;
	logic              byte_en;
	logic [7:0]        byte_val;
	logic [7:0]        pad_byte;
	logic              block_full;
	logic              in_len;
	logic [63:0]       bit_len;
	sbsh_pkg::word_t   t1;
	sbsh_pkg::word_t   t2;
	sbsh_pkg::word_t   w_new;

	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign out_xfer = m_axis_tvalid & m_axis_tready;
	assign bit_len  = {total_q[60:0], 3'b000};
	assign in_len   = sent80_q & (len_q | (fill_q == sbsh_pkg::LEN_POS));

	always_comb begin
		if (!sent80_q) begin
			pad_byte = sbsh_pkg::PAD_MARK;
		end else if (in_len) begin
			// length goes out big-endian over fill positions 56..63
			pad_byte = bit_len[{3'd7 - fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		byte_en  = 1'b0;
		byte_val = s_axis_tdata;
		case (state_q)
			sbsh_pkg::S_IDLE: byte_en = in_xfer & (s_axis_tuser[0] == sbsh_pkg::KIND_BYTE);
			sbsh_pkg::S_PAD: begin
				byte_en  = 1'b1;
				byte_val = pad_byte;
			end
			default: byte_en = 1'b0;
		endcase
	end

	assign block_full = byte_en & (fill_q == sbsh_pkg::LAST_POS);

	// round unit: window slot 0 is W[t]; W[t+16] is formed alongside
	always_comb begin
		t1 = v_q[7] + sbsh_pkg::big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sbsh_pkg::round_k(round_q) + w_q[0];
		t2 = sbsh_pkg::big_s0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = sbsh_pkg::small_s1(w_q[14]) + w_q[9] + sbsh_pkg::small_s0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sbsh_pkg::S_IDLE;
			fill_q   <= '0;
			round_q  <= '0;
			total_q  <= '0;
			idx_q    <= '0;
			pad_q    <= 1'b0;
			sent80_q <= 1'b0;
			len_q    <= 1'b0;
			fin_q    <= 1'b0;
			for (int i = 0; i < sbsh_pkg::WORDS; i++) begin
				chain_q[i] <= sbsh_pkg::init_word(3'(i));
			end
		end else begin
			if (byte_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				sbsh_pkg::S_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser[0] == sbsh_pkg::KIND_END) begin
							state_q <= sbsh_pkg::S_PAD;
							pad_q   <= 1'b1;
						end else begin
							total_q <= total_q + 64'd1;
							if (block_full) begin
								state_q <= sbsh_pkg::S_ROUND;
							end
						end
					end
				end
				sbsh_pkg::S_PAD: begin
					sent80_q <= 1'b1;
					if (in_len) begin
						len_q <= 1'b1;
					end
					if (block_full) begin
						state_q <= sbsh_pkg::S_ROUND;
						if (in_len) begin
							fin_q <= 1'b1;
						end
					end
				end
				sbsh_pkg::S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == sbsh_pkg::LAST_ROUND) begin
						state_q <= sbsh_pkg::S_ADD;
					end
				end
				sbsh_pkg::S_ADD: begin
					for (int i = 0; i < sbsh_pkg::WORDS; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					if (fin_q) begin
						state_q <= sbsh_pkg::S_OUT;
						idx_q   <= '0;
					end else if (pad_q) begin
						state_q <= sbsh_pkg::S_PAD;
					end else begin
						state_q <= sbsh_pkg::S_IDLE;
					end
				end
				sbsh_pkg::S_OUT: begin
					if (out_xfer) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sbsh_pkg::LAST_IDX) begin
							state_q  <= sbsh_pkg::S_IDLE;
							total_q  <= '0;
							pad_q    <= 1'b0;
							sent80_q <= 1'b0;
							len_q    <= 1'b0;
							fin_q    <= 1'b0;
							for (int i = 0; i < sbsh_pkg::WORDS; i++) begin
								chain_q[i] <= sbsh_pkg::init_word(3'(i));
							end
						end
					end
				end
				default: state_q <= sbsh_pkg::S_IDLE;
			endcase
		end
	end

	// datapath: byte shift into the window, load of working words at block end, round updates of window and working words
	always_ff @(posedge clk) begin
		if (byte_en) begin
			for (int i = 0; i < sbsh_pkg::WIN_WORDS - 1; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[sbsh_pkg::WIN_WORDS-1] <= {w_q[sbsh_pkg::WIN_WORDS-1][23:0], byte_val};
		end else if (state_q == sbsh_pkg::S_ROUND) begin
			for (int i = 0; i < sbsh_pkg::WIN_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sbsh_pkg::WIN_WORDS-1] <= w_new;
		end
		if (block_full) begin
			for (int i = 0; i < sbsh_pkg::WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == sbsh_pkg::S_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign s_axis_tready = (state_q == sbsh_pkg::S_IDLE);
	assign m_axis_tvalid = (state_q == sbsh_pkg::S_OUT);
	assign m_axis_tdata  = {5'b00000, idx_q, chain_q[idx_q]};
	assign m_axis_tlast  = (idx_q == sbsh_pkg::LAST_IDX);

endmodule
`default_nettype wire

// ----- rtl/core/sbsh_checker.sv -----
// Port-level checks for the SHA-256 byte stream hasher, bound to the top level.
`default_nettype none
module sbsh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic [0:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	a_last_is_word7: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == sbsh_pkg::LAST_IDX)
		else $error("tlast on a word other than the eighth");

	a_no_input_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while digest words are pending");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
		else $error("digest word index did not advance by one");

	a_end_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == sbsh_pkg::KIND_END
			|=> !s_axis_tready)
		else $error("input ready straight after end of message");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer dropped while stalled");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (.*);
`default_nettype wire
